// ===== src/j1939_bam_message_reassembler_top_assert.svh =====
// Assertion macros shared by the reassembler modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef J1939_BAM_MESSAGE_REASSEMBLER_TOP_ASSERT_SVH
`define J1939_BAM_MESSAGE_REASSEMBLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define JBAM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JBAM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/jbam_pkg.sv =====
package jbam_pkg;

    // Reassembly buffer size and derived widths.
    localparam int BUFFER_BYTES = 64;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);

    // Fixed field widths.
    localparam int ID_W   = 29;
    localparam int PGN_W  = 16;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int POS_W  = 11;
    localparam int STAT_W = 3;

    // Protocol constants.
    localparam int          SEG_BYTES    = 7;
    localparam int          SINGLE_BYTES = 6;
    localparam logic [7:0]  CTRL_BAM     = 8'h20;

    // Register reset values.
    localparam logic [ID_W-1:0]  SINGLE_ID_RST  = 29'h18FECAEF;
    localparam logic [ID_W-1:0]  CONNECT_ID_RST = 29'h1CECFFEF;
    localparam logic [ID_W-1:0]  DATA_ID_RST    = 29'h1CEBFFEF;
    localparam logic [PGN_W-1:0] PGN_RST        = 16'hFECA;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SINGLE_ID  = 2'd0;
    localparam logic [1:0] CFG_CONNECT_ID = 2'd1;
    localparam logic [1:0] CFG_DATA_ID    = 2'd2;
    localparam logic [1:0] CFG_PGN        = 2'd3;

    // Command queue depth (power of two so the pointers wrap by themselves).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_IGNORED   = 3'd0,
        STAT_ARMED     = 3'd1,
        STAT_STORED    = 3'd2,
        STAT_DROPPED   = 3'd3,
        STAT_DELIVERED = 3'd4
    } status_t;

    // Work orders from the front to the back.
    typedef enum logic [1:0] {
        OP_STATUS = 2'd0,   // one result, no storage access
        OP_SINGLE = 2'd1,   // six bytes straight from the frame
        OP_STORE  = 2'd2,   // store a segment, then one result
        OP_FINAL  = 2'd3    // store the last segment, then stream the buffer
    } op_t;

    typedef struct packed {
        op_t                        op;
        status_t                    status;
        logic [LEN_W-1:0]           length;
        logic                       trunc;
        logic [POS_W-1:0]           base;
        logic [SEG_BYTES-1:0][7:0]  data;
    } cmd_t;

endpackage

// ===== src/j1939_bam_message_reassembler_top.sv =====
// Flow: accepted frames enter the command queue; the back end pops one only while idle,
// so it finishes a command before taking the next. It emits one result for a status frame,
// streams a single frame's six bytes, or writes a segment's bytes, then emits its result
// or streams the message, each byte via a READ and a SHOW state (one registered read port).
// Reset: asynchronous; clears the transfer state and the queue, marks every buffer byte
// unwritten so it reads as zero, and restores the default identifiers.
module j1939_bam_message_reassembler_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [jbam_pkg::ID_W-1:0]         cfg_data,
    // Frame input channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [jbam_pkg::ID_W-1:0]         frame_id,
    input  logic [7:0]                        byte_0,
    input  logic [7:0]                        byte_1,
    input  logic [7:0]                        byte_2,
    input  logic [7:0]                        byte_3,
    input  logic [7:0]                        byte_4,
    input  logic [7:0]                        byte_5,
    input  logic [7:0]                        byte_6,
    input  logic [7:0]                        byte_7,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [jbam_pkg::STAT_W-1:0]       status,
    output logic [jbam_pkg::IDX_W-1:0]        byte_index,
    output logic [7:0]                        byte_value,
    output logic [jbam_pkg::LEN_W-1:0]        message_length,
    output logic                              truncated,
    output logic                              last
);

    logic           q_full;
    logic           q_push;
    jbam_pkg::cmd_t q_push_cmd;
    logic           q_pop;
    jbam_pkg::cmd_t q_pop_cmd;
    logic           q_nonempty;

    // Front end: configuration, classification and transfer state.
    jbam_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .frame_id  (frame_id),
        .byte_0    (byte_0),
        .byte_1    (byte_1),
        .byte_2    (byte_2),
        .byte_3    (byte_3),
        .byte_4    (byte_4),
        .byte_5    (byte_5),
        .byte_6    (byte_6),
        .byte_7    (byte_7),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    // Command queue between the two halves.
    jbam_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .nonempty (q_nonempty)
    );

    // Back end: buffer writes and result streaming.
    jbam_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_nonempty     (q_nonempty),
        .q_cmd          (q_pop_cmd),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .byte_index     (byte_index),
        .byte_value     (byte_value),
        .message_length (message_length),
        .truncated      (truncated),
        .last           (last)
    );

endmodule

// ===== src/jbam_ram.sv =====
module jbam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/jbam_queue.sv =====
`include "j1939_bam_message_reassembler_top_assert.svh"

module jbam_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jbam_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output jbam_pkg::cmd_t  pop_cmd,
    output logic            nonempty
);

    jbam_pkg::cmd_t                 q_reg [jbam_pkg::QUEUE_DEPTH];
    logic [jbam_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [jbam_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [jbam_pkg::QPTR_W:0]      count_reg;
    logic [jbam_pkg::QPTR_W:0]      count_next;

    assign full     = (count_reg == (jbam_pkg::QPTR_W + 1)'(jbam_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_cmd  = q_reg[rd_ptr_reg];

    // Occupancy follows the push and pop transactions.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `JBAM_ASSERT_NOW(a_q_no_overflow, push, !full || pop, "queue pushed while full")
    `JBAM_ASSERT_NOW(a_q_no_underflow, pop, count_reg != '0, "queue popped while empty")
    `JBAM_ASSERT_NEXT(a_q_push_holds, push && !pop, count_reg != '0, "pushed entry lost")

endmodule

// ===== src/jbam_front.sv =====
module jbam_front (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [jbam_pkg::ID_W-1:0]       cfg_data,
    // Received frames.
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [jbam_pkg::ID_W-1:0]       frame_id,
    input  logic [7:0]                      byte_0,
    input  logic [7:0]                      byte_1,
    input  logic [7:0]                      byte_2,
    input  logic [7:0]                      byte_3,
    input  logic [7:0]                      byte_4,
    input  logic [7:0]                      byte_5,
    input  logic [7:0]                      byte_6,
    input  logic [7:0]                      byte_7,
    // Commands toward the queue.
    input  logic                            q_full,
    output logic                            q_push,
    output jbam_pkg::cmd_t                  q_cmd
);

    logic [jbam_pkg::ID_W-1:0]  single_id_reg;
    logic [jbam_pkg::ID_W-1:0]  connect_id_reg;
    logic [jbam_pkg::ID_W-1:0]  data_id_reg;
    logic [jbam_pkg::PGN_W-1:0] pgn_reg;

    logic                       active_reg;
    logic                       active_next;
    logic [jbam_pkg::LEN_W-1:0] exp_len_reg;
    logic [jbam_pkg::LEN_W-1:0] exp_len_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [7:0]                 pkt_cnt_reg;
    logic [7:0]                 pkt_cnt_next;

    logic [15:0]                ann_len;
    logic                       ann_ovf;
    logic [jbam_pkg::POS_W-1:0] seq_m1;
    jbam_pkg::cmd_t             cmd;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign q_push    = in_valid && in_ready;
    assign q_cmd     = cmd;

    assign ann_len = {byte_2, byte_1};
    assign ann_ovf = (ann_len > 16'(jbam_pkg::BUFFER_BYTES));
    assign seq_m1  = jbam_pkg::POS_W'(byte_0) - 1'b1;

    // Classify the frame and update the transfer state.
    always_comb
    begin
        active_next  = active_reg;
        exp_len_next = exp_len_reg;
        ovf_next     = ovf_reg;
        pkt_cnt_next = pkt_cnt_reg;

        cmd        = '0;
        cmd.op     = jbam_pkg::OP_STATUS;
        cmd.status = jbam_pkg::STAT_IGNORED;
        // Segment start is seq-1 times seven, formed as eight times minus one.
        cmd.base   = (seq_m1 << 3) - seq_m1;
        cmd.data   = {byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1};

        if (frame_id == single_id_reg)
        begin
            cmd.op     = jbam_pkg::OP_SINGLE;
            cmd.status = jbam_pkg::STAT_DELIVERED;
            cmd.length = jbam_pkg::LEN_W'(jbam_pkg::SINGLE_BYTES);
            cmd.data   = {8'h00, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};
        end
        else if (frame_id == connect_id_reg)
        begin
            if (byte_0 == jbam_pkg::CTRL_BAM && {byte_6, byte_5} == pgn_reg)
            begin
                active_next  = 1'b1;
                ovf_next     = ann_ovf;
                exp_len_next = ann_ovf ? jbam_pkg::LEN_W'(jbam_pkg::BUFFER_BYTES)
                                       : ann_len[jbam_pkg::LEN_W-1:0];
                pkt_cnt_next = byte_3;
                cmd.status   = jbam_pkg::STAT_ARMED;
                cmd.length   = exp_len_next;
                cmd.trunc    = ann_ovf;
            end
        end
        else if (frame_id == data_id_reg && active_reg)
        begin
            cmd.length = exp_len_reg;
            cmd.trunc  = ovf_reg;
            if (byte_0 == 8'h00 || byte_0 > pkt_cnt_reg)
            begin
                cmd.status = jbam_pkg::STAT_DROPPED;
            end
            else if (byte_0 != pkt_cnt_reg)
            begin
                cmd.op     = jbam_pkg::OP_STORE;
                cmd.status = jbam_pkg::STAT_STORED;
            end
            else
            begin
                active_next = 1'b0;
                cmd.status  = jbam_pkg::STAT_DELIVERED;
                // An empty message still gets one delivered result.
                cmd.op      = (exp_len_reg == '0) ? jbam_pkg::OP_STORE : jbam_pkg::OP_FINAL;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_id_reg  <= jbam_pkg::SINGLE_ID_RST;
            connect_id_reg <= jbam_pkg::CONNECT_ID_RST;
            data_id_reg    <= jbam_pkg::DATA_ID_RST;
            pgn_reg        <= jbam_pkg::PGN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jbam_pkg::CFG_SINGLE_ID:  single_id_reg  <= cfg_data;
                jbam_pkg::CFG_CONNECT_ID: connect_id_reg <= cfg_data;
                jbam_pkg::CFG_DATA_ID:    data_id_reg    <= cfg_data;
                jbam_pkg::CFG_PGN:        pgn_reg        <= cfg_data[jbam_pkg::PGN_W-1:0];
                default:                  pgn_reg        <= pgn_reg;
            endcase
        end
    end

    // Transfer state changes only on an accepted frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            exp_len_reg <= '0;
            ovf_reg     <= 1'b0;
            pkt_cnt_reg <= '0;
        end
        else if (q_push)
        begin
            active_reg  <= active_next;
            exp_len_reg <= exp_len_next;
            ovf_reg     <= ovf_next;
            pkt_cnt_reg <= pkt_cnt_next;
        end
    end

endmodule

// ===== src/jbam_back.sv =====
`include "j1939_bam_message_reassembler_top_assert.svh"

module jbam_back (
    input  logic                              clk,
    input  logic                              rst_n,
    // Commands from the queue.
    input  logic                              q_nonempty,
    input  jbam_pkg::cmd_t                    q_cmd,
    output logic                              q_pop,
    // Results.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [jbam_pkg::STAT_W-1:0]       status,
    output logic [jbam_pkg::IDX_W-1:0]        byte_index,
    output logic [7:0]                        byte_value,
    output logic [jbam_pkg::LEN_W-1:0]        message_length,
    output logic                              truncated,
    output logic                              last
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_WRITE  = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SHOW   = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_SINGLE = 6'b100000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    jbam_pkg::cmd_t                 cmd_reg;
    logic [jbam_pkg::ADDR_W-1:0]    cnt_reg;
    logic [jbam_pkg::ADDR_W-1:0]    cnt_next;
    logic [jbam_pkg::BUFFER_BYTES-1:0] vld_reg;
    logic                           vbit_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [jbam_pkg::STAT_W-1:0]    status_reg;
    logic [jbam_pkg::STAT_W-1:0]    status_next;
    logic [jbam_pkg::IDX_W-1:0]     index_reg;
    logic [jbam_pkg::IDX_W-1:0]     index_next;
    logic [7:0]                     value_reg;
    logic [7:0]                     value_next;
    logic [jbam_pkg::LEN_W-1:0]     length_reg;
    logic [jbam_pkg::LEN_W-1:0]     length_next;
    logic                           trunc_reg;
    logic                           trunc_next;
    logic                           last_reg;
    logic                           last_next;

    logic                           slot_free;
    logic [jbam_pkg::POS_W-1:0]     wr_pos;
    logic                           wr_en;
    logic [7:0]                     wr_data;
    logic                           rd_en;
    logic [7:0]                     rd_data;
    logic                           show_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_nonempty;

    // Segment bytes land at base plus offset; bytes past the buffer are dropped.
    assign wr_pos    = cmd_reg.base + jbam_pkg::POS_W'(cnt_reg);
    assign wr_en     = (state_reg == ST_WRITE)
                       && (wr_pos < jbam_pkg::POS_W'(jbam_pkg::BUFFER_BYTES));
    assign wr_data   = cmd_reg.data[cnt_reg[2:0]];
    assign rd_en     = (state_reg == ST_READ);
    assign show_last = ((jbam_pkg::LEN_W'(cnt_reg) + 1'b1) == cmd_reg.length);

    jbam_ram #(
        .WIDTH (8),
        .DEPTH (jbam_pkg::BUFFER_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_pos[jbam_pkg::ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    // Sequencer and result register loading.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        length_next    = length_reg;
        trunc_next     = trunc_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (q_nonempty)
                begin
                    case (q_cmd.op)
                        jbam_pkg::OP_STATUS: state_next = ST_EMIT;
                        jbam_pkg::OP_SINGLE: state_next = ST_SINGLE;
                        default:             state_next = ST_WRITE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                if (cnt_reg == jbam_pkg::ADDR_W'(jbam_pkg::SEG_BYTES - 1))
                begin
                    cnt_next   = '0;
                    state_next = (cmd_reg.op == jbam_pkg::OP_FINAL) ? ST_READ : ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = jbam_pkg::STAT_DELIVERED;
                    index_next     = jbam_pkg::IDX_W'(cnt_reg);
                    value_next     = vbit_reg ? rd_data : 8'h00;
                    length_next    = cmd_reg.length;
                    trunc_next     = cmd_reg.trunc;
                    last_next      = show_last;
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = show_last ? ST_IDLE : ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = cmd_reg.status;
                    index_next     = '0;
                    value_next     = 8'h00;
                    length_next    = cmd_reg.length;
                    trunc_next     = cmd_reg.trunc;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SINGLE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = jbam_pkg::STAT_DELIVERED;
                    index_next     = jbam_pkg::IDX_W'(cnt_reg);
                    value_next     = cmd_reg.data[cnt_reg[2:0]];
                    length_next    = cmd_reg.length;
                    trunc_next     = 1'b0;
                    last_next      = (cnt_reg == jbam_pkg::ADDR_W'(jbam_pkg::SINGLE_BYTES - 1));
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = last_next ? ST_IDLE : ST_SINGLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers; the byte valid bits make unwritten entries read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                vld_reg[wr_pos[jbam_pkg::ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (rd_en)
        begin
            vbit_reg <= vld_reg[cnt_reg];
        end
        status_reg <= status_next;
        index_reg  <= index_next;
        value_reg  <= value_next;
        length_reg <= length_next;
        trunc_reg  <= trunc_next;
        last_reg   <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign byte_index     = index_reg;
    assign byte_value     = value_reg;
    assign message_length = length_reg;
    assign truncated      = trunc_reg;
    assign last           = last_reg;

    `JBAM_ASSERT_NOW(a_bk_plain_zero, out_valid && status != jbam_pkg::STAT_DELIVERED, byte_index == '0 && byte_value == 8'h00, "non-delivery result carries a byte")
    `JBAM_ASSERT_NOW(a_bk_last_len, out_valid && last && status == jbam_pkg::STAT_DELIVERED, (jbam_pkg::LEN_W'(byte_index) + 1'b1 == message_length) || message_length == '0, "last byte does not close the message")
    `JBAM_ASSERT_NEXT(a_bk_pop_busy, q_pop, state_reg != ST_IDLE, "command popped but sequencer stayed idle")

endmodule
